>>> src/frt_pkg.sv
// ----------------------------------------------------------------------------
// frt_pkg: shared types and constants of the flow id route table
// Holds the item and result word formats, table sizing, status codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int ADDR_BYTES  = 2;

  localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int OUT_IDX_W = 5;

  // Addresses keep only their low 8*ADDR_BYTES bits, capped at the 16-bit field.
  localparam int ADDR_W = (ADDR_BYTES >= 2) ? 16 : 8 * ADDR_BYTES;
  localparam logic [15:0] ADDR_MASK = 16'((33'd1 << ADDR_W) - 33'd1);

  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic MARK_NEW     = 1'b0;
  localparam logic MARK_UPDATED = 1'b1;

  localparam logic [2:0] STAT_INSERTED  = 3'd0;
  localparam logic [2:0] STAT_UPDATED   = 3'd1;
  localparam logic [2:0] STAT_UNCHANGED = 3'd2;
  localparam logic [2:0] STAT_FULL      = 3'd3;
  localparam logic [2:0] STAT_MISS      = 3'd4;
  localparam logic [2:0] STAT_HIT       = 3'd5;

  typedef struct packed {
    logic        action;
    logic [15:0] source_addr;
    logic [15:0] flow_id;
    logic [15:0] next_hop_addr;
    logic [7:0]  route_action;
  } frt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  entry_index;
    logic [15:0] stored_next_hop;
    logic [7:0]  stored_route_action;
    logic        route_mark;
  } frt_out_t;

  typedef struct packed {
    logic [15:0] source;
    logic [15:0] flow;
    logic [15:0] hop_addr;
    logic [7:0]  action;
    logic        mark;
  } frt_entry_t;

  localparam int ENTRY_W = $bits(frt_entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } frt_state_t;

endpackage

>>> src/frt_ram.sv
// ----------------------------------------------------------------------------
// frt_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module frt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/flow_id_route_table.sv
// ----------------------------------------------------------------------------
// flow_id_route_table: exact-match route table keyed on source and flow id
// Add words insert a new route or update an existing one; lookup words report
// the stored route. Entries live in one RAM and are scanned linearly.
// ----------------------------------------------------------------------------
//
//   channel | ports                      | word
//   --------+----------------------------+---------------------------------
//   input   | in_valid, in_ready, in_data   | frt_in_t: action, key, route
//   result  | out_valid, out_ready, out_data| frt_out_t: status, slot, entry
//
// One word at a time. Each word is accepted, then scanned slot by slot up to
// the match (at most the entry count), then decided with any write-back, and
// then emitted. The scan rate is set by the single RAM read port, one slot
// per cycle. Reset clears the state, the entry count and the result valid
// flag; RAM contents need no clearing since only slots below the count are
// ever read. A stalled result holds in the output register while the next
// word is already accepted and scanned.
//
module flow_id_route_table
  import frt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  frt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output frt_out_t out_data
);

  frt_state_t state_r, state_nxt;

  frt_in_t    item_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] scan_idx_r;
  logic             pend_vld_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  frt_entry_t       hit_ent_r;
  frt_out_t         res_r, res_nxt;
  logic             out_valid_r;
  frt_out_t         out_data_r;

  // RAM interface
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  frt_entry_t       ram_wdata, rd_ent;
  logic [ENTRY_W-1:0] ram_rdata;

  logic key_match, scan_more, out_free, in_acc;
  logic [IDX_W+OUT_IDX_W-1:0] idx_ext;

  frt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent = frt_entry_t'(ram_rdata);

  // Compare the slot read last cycle against the key of the word in flight.
  assign key_match = pend_vld_r && (rd_ent.source == item_r.source_addr)
                     && (rd_ent.flow == item_r.flow_id);
  assign scan_more = (scan_idx_r < count_r);
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (key_match || !scan_more) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Read side: issue the next slot unless this cycle already hit.
  assign ram_re    = (state_r == ST_SCAN) && !key_match && scan_more;
  assign ram_raddr = scan_idx_r[IDX_W-1:0];

  // Decide: build the result and the write-back from the scan outcome.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_idx_r;
    ram_wdata = '0;
    count_nxt = count_r;
    res_nxt   = res_r;
    idx_ext   = '0;
    if (state_r == ST_DECIDE) begin
      res_nxt = '0;
      if (item_r.action == ACT_LOOKUP) begin
        if (hit_r) begin
          idx_ext                     = {{OUT_IDX_W{1'b0}}, hit_idx_r};
          res_nxt.status              = STAT_HIT;
          res_nxt.entry_index         = idx_ext[OUT_IDX_W-1:0];
          res_nxt.stored_next_hop     = hit_ent_r.hop_addr;
          res_nxt.stored_route_action = hit_ent_r.action;
          res_nxt.route_mark          = hit_ent_r.mark;
        end else begin
          res_nxt.status = STAT_MISS;
        end
      end else if (!hit_r) begin
        if (count_r == CNT_W'(TABLE_DEPTH)) begin
          res_nxt.status = STAT_FULL;
        end else begin
          // Append at the next free slot, marked new.
          ram_we             = 1'b1;
          ram_waddr          = count_r[IDX_W-1:0];
          ram_wdata.source   = item_r.source_addr;
          ram_wdata.flow     = item_r.flow_id;
          ram_wdata.hop_addr = item_r.next_hop_addr;
          ram_wdata.action   = item_r.route_action;
          ram_wdata.mark     = MARK_NEW;
          count_nxt          = count_r + CNT_W'(1);
          idx_ext                     = {{OUT_IDX_W{1'b0}}, count_r[IDX_W-1:0]};
          res_nxt.status              = STAT_INSERTED;
          res_nxt.entry_index         = idx_ext[OUT_IDX_W-1:0];
          res_nxt.stored_next_hop     = item_r.next_hop_addr;
          res_nxt.stored_route_action = item_r.route_action;
          res_nxt.route_mark          = MARK_NEW;
        end
      end else begin
        idx_ext             = {{OUT_IDX_W{1'b0}}, hit_idx_r};
        res_nxt.entry_index = idx_ext[OUT_IDX_W-1:0];
        if ((hit_ent_r.hop_addr != item_r.next_hop_addr)
            || (hit_ent_r.action != item_r.route_action)) begin
          // Rewrite the route in place and mark it updated.
          ram_we             = 1'b1;
          ram_wdata.source   = hit_ent_r.source;
          ram_wdata.flow     = hit_ent_r.flow;
          ram_wdata.hop_addr = item_r.next_hop_addr;
          ram_wdata.action   = item_r.route_action;
          ram_wdata.mark     = MARK_UPDATED;
          res_nxt.status              = STAT_UPDATED;
          res_nxt.stored_next_hop     = item_r.next_hop_addr;
          res_nxt.stored_route_action = item_r.route_action;
          res_nxt.route_mark          = MARK_UPDATED;
        end else begin
          res_nxt.status              = STAT_UNCHANGED;
          res_nxt.stored_next_hop     = hit_ent_r.hop_addr;
          res_nxt.stored_route_action = hit_ent_r.action;
          res_nxt.route_mark          = hit_ent_r.mark;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scan and payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      // Hold the word, trimmed to the kept address width.
      item_r.action        <= in_data.action;
      item_r.source_addr   <= in_data.source_addr & ADDR_MASK;
      item_r.flow_id       <= in_data.flow_id;
      item_r.next_hop_addr <= in_data.next_hop_addr & ADDR_MASK;
      item_r.route_action  <= in_data.route_action;
      scan_idx_r           <= '0;
      pend_vld_r           <= 1'b0;
      hit_r                <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      pend_vld_r <= ram_re;
      pend_idx_r <= scan_idx_r[IDX_W-1:0];
      if (ram_re) scan_idx_r <= scan_idx_r + CNT_W'(1);
      if (key_match) begin
        hit_r     <= 1'b1;
        hit_idx_r <= pend_idx_r;
        hit_ent_r <= rd_ent;
      end
    end
    res_r <= res_nxt;
    if (state_r == ST_EMIT && out_free) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("RAM read and write in the same cycle");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside emit");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> $past(state_r == ST_DECIDE && ram_we))
    else $error("entry count moved without an insert");
`endif

endmodule

>>> test/tb_flow_id_route_table.sv
// ----------------------------------------------------------------------------
// tb_flow_id_route_table: self-checking bench for the flow id route table
// Drives add and lookup words through the valid/ready input channel, keeps a
// shadow copy of the route table to predict every result word, and checks
// the result channel field by field. Both channels idle in random bursts
// until the last stretch of the run, where they stream without gaps.
// ----------------------------------------------------------------------------
module tb_flow_id_route_table;
  import frt_pkg::*;

  localparam int TAIL_WORDS   = 60;   // last words of the run go without idling
  localparam int RANDOM_WORDS = 700;
  localparam int KEY_POOL_MAX = TABLE_DEPTH + 8;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  frt_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  frt_out_t out_data;

  flow_id_route_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Words still to be sent, and result words still owed by the block.
  frt_in_t  route_words[$];
  frt_out_t route_answers[$];
  int       mismatches = 0;

  // Shadow route table: the block's state as this bench sees it.
  int          shadow_count = 0;
  logic [15:0] shadow_src[TABLE_DEPTH];
  logic [15:0] shadow_flow[TABLE_DEPTH];
  logic [15:0] shadow_hop[TABLE_DEPTH];
  logic [7:0]  shadow_act[TABLE_DEPTH];
  logic        shadow_mark[TABLE_DEPTH];

  // Keys the stimulus has added, with the route it last sent for each. Used
  // only to steer the random words toward hits, updates and unchanged adds.
  logic [15:0] pool_src[$];
  logic [15:0] pool_flow[$];
  logic [15:0] pool_hop[$];
  logic [7:0]  pool_act[$];

  int in_gap  = 0;
  int out_gap = 0;

  // Apply one accepted word to the shadow table and return the result word
  // that the block owes for it.
  function automatic frt_out_t route_table_apply(frt_in_t w);
    frt_out_t    res;
    logic [15:0] src;
    logic [15:0] hop;
    int          slot;
    bit          hit;
    src  = w.source_addr & ADDR_MASK;
    hop  = w.next_hop_addr & ADDR_MASK;
    res  = '0;
    slot = 0;
    hit  = 1'b0;
    // Scan only slots that hold a route; first match wins.
    for (int i = 0; i < shadow_count; i++) begin
      if (!hit && shadow_src[i] == src && shadow_flow[i] == w.flow_id) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    if (w.action == ACT_LOOKUP) begin
      res.status = hit ? STAT_HIT : STAT_MISS;
      if (!hit) return res;
    end else if (!hit) begin
      // Full table on a miss: drop the word, report full with all other fields zero.
      if (shadow_count >= TABLE_DEPTH) begin
        res.status = STAT_FULL;
        return res;
      end
      slot              = shadow_count;
      shadow_src[slot]  = src;
      shadow_flow[slot] = w.flow_id;
      shadow_hop[slot]  = hop;
      shadow_act[slot]  = w.route_action;
      shadow_mark[slot] = MARK_NEW;
      shadow_count++;
      res.status = STAT_INSERTED;
    end else if (shadow_hop[slot] != hop || shadow_act[slot] != w.route_action) begin
      shadow_hop[slot]  = hop;
      shadow_act[slot]  = w.route_action;
      shadow_mark[slot] = MARK_UPDATED;
      res.status = STAT_UPDATED;
    end else begin
      res.status = STAT_UNCHANGED;
    end
    res.entry_index         = slot[4:0];
    res.stored_next_hop     = shadow_hop[slot];
    res.stored_route_action = shadow_act[slot];
    res.route_mark          = shadow_mark[slot];
    return res;
  endfunction

  function automatic int pool_find(logic [15:0] src, logic [15:0] flow);
    for (int i = 0; i < pool_src.size(); i++)
      if (pool_src[i] == src && pool_flow[i] == flow) return i;
    return -1;
  endfunction

  // Queue one word for the driver and, for an add, note the route it carries.
  function automatic void queue_word(logic action, logic [15:0] src, logic [15:0] flow,
                                     logic [15:0] hop, logic [7:0] act);
    frt_in_t w;
    int      k;
    w.action        = action;
    w.source_addr   = src;
    w.flow_id       = flow;
    w.next_hop_addr = hop;
    w.route_action  = act;
    route_words.push_back(w);
    if (action == ACT_ADD) begin
      k = pool_find(src, flow);
      if (k >= 0) begin
        pool_hop[k] = hop;
        pool_act[k] = act;
      end else if (pool_src.size() < KEY_POOL_MAX) begin
        pool_src.push_back(src);
        pool_flow.push_back(flow);
        pool_hop.push_back(hop);
        pool_act.push_back(act);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Driver: hold the word until accepted, predict on acceptance, then either
  // idle for a burst or present the next pending word.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) route_answers.push_back(route_table_apply(in_data));
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (route_words.size() >= TAIL_WORDS && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else if (route_words.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= route_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result word against the oldest prediction,
  // and stall the result channel in random bursts.
  frt_out_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (route_answers.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual %p", $time, out_data);
          mismatches++;
        end else begin
          want = route_answers.pop_front();
          check_field("status", 16'(want.status), 16'(out_data.status));
          check_field("entry_index", 16'(want.entry_index), 16'(out_data.entry_index));
          check_field("stored_next_hop", want.stored_next_hop, out_data.stored_next_hop);
          check_field("stored_route_action", 16'(want.stored_route_action),
                      16'(out_data.stored_route_action));
          check_field("route_mark", 16'(want.route_mark), 16'(out_data.route_mark));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (route_words.size() >= TAIL_WORDS && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  logic [15:0] r_src;
  logic [15:0] r_flow;
  logic [15:0] r_hop;
  logic [7:0]  r_act;
  logic        r_action;
  int          pick;

  initial begin
    // Directed part: empty-table lookup, field extremes, every status but
    // table full, partial key matches, update on action alone.
    queue_word(ACT_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 8'h00);
    queue_word(ACT_ADD,    16'h0000, 16'h0000, 16'h0000, 8'h00);
    queue_word(ACT_ADD,    16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    queue_word(ACT_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000, 8'h00);
    queue_word(ACT_ADD,    16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    queue_word(ACT_ADD,    16'hFFFF, 16'hFFFF, 16'h0000, 8'hFF);
    queue_word(ACT_ADD,    16'h0000, 16'h0000, 16'h0000, 8'h80);
    queue_word(ACT_LOOKUP, 16'h0000, 16'h0000, 16'hFFFF, 8'hFF);
    queue_word(ACT_ADD,    16'h0000, 16'hFFFF, 16'h1234, 8'h5A);
    queue_word(ACT_ADD,    16'hFFFF, 16'h0000, 16'h8001, 8'hA5);
    queue_word(ACT_LOOKUP, 16'hFFFF, 16'h0001, 16'h0000, 8'h00);
    queue_word(ACT_ADD,    16'h0000, 16'h0000, 16'h0000, 8'h80);
    queue_word(ACT_ADD,    16'h0000, 16'h0000, 16'h8000, 8'h01);
    queue_word(ACT_ADD,    16'hAAAA, 16'h5555, 16'h5555, 8'hAA);
    queue_word(ACT_ADD,    16'h5555, 16'hAAAA, 16'hAAAA, 8'h55);
    queue_word(ACT_LOOKUP, 16'h5555, 16'hAAAA, 16'h0000, 8'h00);
    queue_word(ACT_LOOKUP, 16'h0000, 16'hFFFF, 16'hFFFF, 8'hFF);
    queue_word(ACT_LOOKUP, 16'hAAAA, 16'hAAAA, 16'h0000, 8'h00);

    // Random part: mostly known keys so the table fills, hits and updates;
    // fresh keys keep inserting until the table is full, then probe it.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      r_action = ($urandom_range(0, 99) < 30) ? ACT_LOOKUP : ACT_ADD;
      r_hop    = 16'($urandom);
      r_act    = 8'($urandom);
      if (pool_src.size() > 0 && $urandom_range(0, 99) < 60) begin
        pick   = $urandom_range(0, pool_src.size() - 1);
        r_src  = pool_src[pick];
        r_flow = pool_flow[pick];
        case ($urandom_range(0, 9))
          0: r_src  = 16'($urandom);   // same flow, other source
          1: r_flow = 16'($urandom);   // same source, other flow
          2, 3, 4: begin
            r_hop = pool_hop[pick];
            r_act = pool_act[pick];
          end
          5: r_hop = pool_hop[pick];   // change the action only
          6: r_act = pool_act[pick];   // change the next hop only
          default: ;
        endcase
      end else begin
        r_src  = 16'($urandom);
        r_flow = 16'($urandom);
      end
      queue_word(r_action, r_src, r_flow, r_hop, r_act);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: nothing pending, nothing owed, then let the pipe settle.
    while (route_words.size() > 0 || in_valid || route_answers.size() > 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (mismatches == 0 && route_answers.size() == 0) begin
      $display("** flow_id_route_table: PASSED **");
    end else begin
      $display("** flow_id_route_table: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #8000000;
    $display("%0t: timeout", $time);
    $display("** flow_id_route_table: FAILED **");
    $finish;
  end

endmodule

>>> flow_id_route_table.f
src/frt_pkg.sv
src/frt_ram.sv
src/flow_id_route_table.sv
test/tb_flow_id_route_table.sv
